// File: rtl/cbct_pkg.sv
// Shared types and constants for the circle/box collision test.
package cbct_pkg;

  localparam logic [1:0] KIND_CC = 2'd0;
  localparam logic [1:0] KIND_BB = 2'd1;
  localparam logic [1:0] KIND_BC = 2'd2;
  localparam logic [1:0] KIND_CB = 2'd3;

  // Work vector magnitudes after the front end (33 bits max)
  localparam int VW = 34;

  // Per-item control carried down the pipeline
  typedef struct packed {
    logic       hit;
    logic       use_norm;   // normal comes from vector normalization
    logic       neg;        // negate final normal
    logic       sx;         // sign of vector x
    logic       sy;         // sign of vector y
    logic [1:0] axis_x;     // axis normal x: 0 zero, 1 plus, 2 minus
    logic [1:0] axis_y;
  } ctl_t;

endpackage

// File: rtl/cbct_norm.sv
// Pipelined vector normalization: scale, square, square root, divide.
module cbct_norm import cbct_pkg::*; #(
  parameter int NFB = 14
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic [VW-1:0] ax_in,
  input  logic [VW-1:0] ay_in,
  output logic [NFB:0]  qx,
  output logic [NFB:0]  qy
);

  // Square root and divide steps, one bit per stage
  localparam int SQ = 33;
  localparam int NW = 32 + NFB;  // numerator width
  localparam int QB = NFB + 2;   // quotient bits

  // Stage 0: scale so the larger magnitude sits in [2^31, 2^32)
  logic [VW-1:0] m;
  logic [5:0]    lz;
  logic [VW-1:0] ax_s, ay_s;
  always_comb begin
    m = (ax_in > ay_in) ? ax_in : ay_in;
    lz = 6'd0;
    for (int i = 0; i < 32; i++) begin
      if (m[i]) lz = 6'(31 - i);
    end
    if (m == '0) lz = 6'd0;
    ax_s = ax_in << lz;
    ay_s = ay_in << lz;
  end

  logic [31:0] a0x, a0y;
  always_ff @(posedge clk) begin
    if (en) begin
      a0x <= ax_s[31:0];
      a0y <= ay_s[31:0];
    end
  end

  // Stage 1: squares (two multipliers)
  logic [63:0] p1x, p1y;
  logic [31:0] a1x, a1y;
  always_ff @(posedge clk) begin
    if (en) begin
      p1x <= 64'(a0x) * 64'(a0x);
      p1y <= 64'(a0y) * 64'(a0y);
      a1x <= a0x;
      a1y <= a0y;
    end
  end

  // Stage 2: sum of squares
  logic [64:0] d2;
  logic [31:0] a2x, a2y;
  always_ff @(posedge clk) begin
    if (en) begin
      d2  <= 65'(p1x) + 65'(p1y);
      a2x <= a1x;
      a2y <= a1y;
    end
  end

  // Square root: restoring, one result bit per stage
  logic [66:0] sr_rem [SQ+1];
  logic [32:0] sr_res [SQ+1];
  logic [64:0] sr_d   [SQ+1];
  logic [31:0] sr_x   [SQ+1];
  logic [31:0] sr_y   [SQ+1];
  always_comb begin
    sr_rem[0] = '0;
    sr_res[0] = '0;
    sr_d[0]   = d2;
    sr_x[0]   = a2x;
    sr_y[0]   = a2y;
  end

  for (genvar s = 0; s < SQ; s++) begin : g_sqrt
    localparam int B = 32 - s;
    logic [66:0] rem_sh, trial;
    always_comb begin
      rem_sh = {sr_rem[s][64:0], 2'b00} | 67'(sr_d[s] >> (2 * B) & 65'd3);
      trial  = {32'd0, sr_res[s], 2'b01};
    end
    always_ff @(posedge clk) begin
      if (en) begin
        if (rem_sh >= trial) begin
          sr_rem[s+1] <= rem_sh - trial;
          sr_res[s+1] <= {sr_res[s][31:0], 1'b1};
        end else begin
          sr_rem[s+1] <= rem_sh;
          sr_res[s+1] <= {sr_res[s][31:0], 1'b0};
        end
        sr_d[s+1] <= sr_d[s];
        sr_x[s+1] <= sr_x[s];
        sr_y[s+1] <= sr_y[s];
      end
    end
  end

  // Numerators with rounding term
  logic [NW:0] nx0, ny0;
  logic [32:0] len;
  always_ff @(posedge clk) begin
    if (en) begin
      len <= sr_res[SQ];
      nx0 <= (NW+1)'({sr_x[SQ], {NFB{1'b0}}}) + (NW+1)'(sr_res[SQ] >> 1);
      ny0 <= (NW+1)'({sr_y[SQ], {NFB{1'b0}}}) + (NW+1)'(sr_res[SQ] >> 1);
    end
  end

  // Division: quotient < 2^(NFB+1), one bit per stage; len >= 2^31
  logic [NW:0]   dv_rx [QB+1];
  logic [NW:0]   dv_ry [QB+1];
  logic [QB-1:0] dv_qx [QB+1];
  logic [QB-1:0] dv_qy [QB+1];
  logic [32:0]   dv_l  [QB+1];
  always_comb begin
    dv_rx[0] = nx0;
    dv_ry[0] = ny0;
    dv_qx[0] = '0;
    dv_qy[0] = '0;
    dv_l[0]  = len;
  end

  for (genvar s = 0; s < QB; s++) begin : g_div
    localparam int B = QB - 1 - s;
    logic [NW+QB:0] shx, shy;
    always_comb begin
      shx = (NW+QB+1)'(dv_l[s]) << B;
      shy = shx;
    end
    always_ff @(posedge clk) begin
      if (en) begin
        if ((NW+QB+1)'(dv_rx[s]) >= shx) begin
          dv_rx[s+1] <= dv_rx[s] - shx[NW:0];
          dv_qx[s+1] <= dv_qx[s] | (QB'(1) << B);
        end else begin
          dv_rx[s+1] <= dv_rx[s];
          dv_qx[s+1] <= dv_qx[s];
        end
        if ((NW+QB+1)'(dv_ry[s]) >= shy) begin
          dv_ry[s+1] <= dv_ry[s] - shy[NW:0];
          dv_qy[s+1] <= dv_qy[s] | (QB'(1) << B);
        end else begin
          dv_ry[s+1] <= dv_ry[s];
          dv_qy[s+1] <= dv_qy[s];
        end
        dv_l[s+1] <= dv_l[s];
      end
    end
  end

  assign qx = dv_qx[QB][NFB:0];
  assign qy = dv_qy[QB][NFB:0];

  // rst unused by datapath registers; control sits in the top level
  logic unused_rst;
  assign unused_rst = rst;

endmodule

// File: rtl/circle_box_collision_test.sv
// Top level of the circle/box collision test pipeline.
//
// Usage: one shape pair enters on the s_axis group per transfer; one result
// leaves on m_axis per pair, in order. tdata in: self_x, self_y, self_size_a,
// self_size_b, other_x, other_y, other_size_a, other_size_b (lowest first);
// tuser in: req_type. tdata out: normal_x, normal_y; tuser out: collided.
// Throughput: one pair per cycle while the output is not stalled. The pipeline
// has 2 + 3 + 34 + (NORMAL_FRAC_BITS + 2) + 1 register stages (front end, scale,
// square, sum, square root bit stages plus rounding, divider bit stages, output).
// The whole pipeline advances together; when m_axis_tready is low and the
// output stage holds a result, the pipeline freezes and s_axis_tready drops
// until that result is taken, so nothing is lost or repeated.
// Reset (rst, synchronous) clears all valid bits; data registers keep junk.
// COORD_FRAC_BITS only documents the input format: the tests are scale free.
module circle_box_collision_test import cbct_pkg::*; #(
  parameter int COORD_FRAC_BITS  = 16,
  parameter int NORMAL_FRAC_BITS = 14
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // self_x, self_y, self_size_a, self_size_b, other_x, other_y,
  // other_size_a, other_size_b, zero pad to 256 bits
  input  logic [255:0] s_axis_tdata,
  // req_type
  input  logic [1:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // normal_x, normal_y
  output logic [31:0]  m_axis_tdata,
  // collided
  output logic         m_axis_tuser
);

  localparam int NFB = NORMAL_FRAC_BITS;
  localparam int LAT = 2 + 3 + 34 + (NFB + 2) + 1;
  localparam int unused_cfb = COORD_FRAC_BITS;

  // Field unpack
  logic [1:0]         kind;
  logic signed [33:0] sx, sy, ox, oy;
  logic signed [33:0] sa, sb, oa, ob;
  always_comb begin
    kind = s_axis_tuser;
    sx = 34'(signed'(s_axis_tdata[31:0]));
    sy = 34'(signed'(s_axis_tdata[63:32]));
    sa = 34'(s_axis_tdata[94:64]);
    sb = 34'(s_axis_tdata[125:95]);
    ox = 34'(signed'(s_axis_tdata[157:126]));
    oy = 34'(signed'(s_axis_tdata[189:158]));
    oa = 34'(s_axis_tdata[220:190]);
    ob = 34'(s_axis_tdata[251:221]);
  end

  // Pipeline valid chain and advance
  logic [LAT-1:0] vld;
  logic           en;
  assign en = !vld[LAT-1] || m_axis_tready;
  assign s_axis_tready = en;
  assign m_axis_tvalid = vld[LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAT-2:0], s_axis_tvalid};
    end
  end

  // Front stage 1: role swap and differences
  logic               f1_kind_cc, f1_kind_bb, f1_neg;
  logic signed [34:0] f1_dx, f1_dy;
  logic signed [34:0] f1_hw, f1_hh, f1_r, f1_ex, f1_ey;
  always_ff @(posedge clk) begin
    if (en) begin
      f1_kind_cc <= (kind == KIND_CC);
      f1_kind_bb <= (kind == KIND_BB);
      f1_neg     <= (kind == KIND_CB);
      case (kind)
        KIND_CC: begin
          f1_dx <= 35'(sx) - 35'(ox);
          f1_dy <= 35'(sy) - 35'(oy);
          f1_hw <= '0; f1_hh <= '0;
          f1_r  <= 35'(sa) + 35'(oa);
          f1_ex <= '0; f1_ey <= '0;
        end
        KIND_BB: begin
          f1_dx <= 35'(ox) - 35'(sx);
          f1_dy <= 35'(oy) - 35'(sy);
          f1_hw <= '0; f1_hh <= '0; f1_r <= '0;
          f1_ex <= 35'(sa) + 35'(oa);
          f1_ey <= 35'(sb) + 35'(ob);
        end
        KIND_BC: begin
          f1_dx <= 35'(ox) - 35'(sx);
          f1_dy <= 35'(oy) - 35'(sy);
          f1_hw <= 35'(sa); f1_hh <= 35'(sb); f1_r <= 35'(oa);
          f1_ex <= 35'(sa) + 35'(oa);
          f1_ey <= 35'(sb) + 35'(oa);
        end
        default: begin
          f1_dx <= 35'(sx) - 35'(ox);
          f1_dy <= 35'(sy) - 35'(oy);
          f1_hw <= 35'(oa); f1_hh <= 35'(ob); f1_r <= 35'(sa);
          f1_ex <= 35'(oa) + 35'(sa);
          f1_ey <= 35'(ob) + 35'(sa);
        end
      endcase
    end
  end

  // Front stage 2 logic: clamp, gap, penetrations, axis choice
  logic signed [34:0] px, py, gx, gy, adx, ady, xp, yp;
  logic               bc_zero;
  ctl_t               c2_next;
  logic [VW-1:0]      vx_next, vy_next;
  logic               cc_zero;
  always_comb begin
    px = (f1_dx > f1_hw) ? f1_hw : ((f1_dx < -f1_hw) ? -f1_hw : f1_dx);
    py = (f1_dy > f1_hh) ? f1_hh : ((f1_dy < -f1_hh) ? -f1_hh : f1_dy);
    gx = px - f1_dx;
    gy = py - f1_dy;
    adx = f1_dx[34] ? -f1_dx : f1_dx;
    ady = f1_dy[34] ? -f1_dy : f1_dy;
    xp = f1_ex - adx;
    yp = f1_ey - ady;
    bc_zero = (gx == 0) && (gy == 0);
    cc_zero = (f1_dx == 0) && (f1_dy == 0);
    c2_next = '0;
    c2_next.neg = f1_neg;
    if (f1_kind_cc) begin
      c2_next.use_norm = 1'b1;
      c2_next.sx = f1_dx[34];
      c2_next.sy = f1_dy[34];
      vx_next = VW'(adx);
      vy_next = VW'(ady);
      if (cc_zero) c2_next.use_norm = 1'b0;
    end else if (f1_kind_bb) begin
      vx_next = '0; vy_next = '0;
      c2_next.hit = (xp > 0) && (yp > 0);
      if (xp < yp) c2_next.axis_x = f1_dx[34] ? 2'd1 : 2'd2;
      else         c2_next.axis_y = f1_dy[34] ? 2'd1 : 2'd2;
    end else begin
      c2_next.sx = gx[34];
      c2_next.sy = gy[34];
      vx_next = VW'(gx[34] ? -gx : gx);
      vy_next = VW'(gy[34] ? -gy : gy);
      c2_next.use_norm = !bc_zero;
      if (bc_zero) begin
        if (xp < yp) c2_next.axis_x = f1_dx[34] ? 2'd1 : 2'd2;
        else         c2_next.axis_y = f1_dy[34] ? 2'd1 : 2'd2;
      end
    end
  end

  ctl_t          c2;
  logic [VW-1:0] v2x, v2y;
  logic [67:0]   t2;   // threshold: radius, or radius sum for circle pairs
  logic          c2_cc, c2_bb;
  always_ff @(posedge clk) begin
    if (en) begin
      c2    <= c2_next;
      v2x   <= vx_next;
      v2y   <= vy_next;
      t2    <= 68'(f1_r[33:0]);
      c2_cc <= f1_kind_cc;
      c2_bb <= f1_kind_bb;
    end
  end

  // Hit test stages for circle kinds: square, sum, compare
  logic [67:0] h3x, h3y, h3r;
  ctl_t        c3;
  logic        c3_cc, c3_bb;
  always_ff @(posedge clk) begin
    if (en) begin
      h3x <= 68'(v2x[32:0]) * 68'(v2x[32:0]);
      h3y <= 68'(v2y[32:0]) * 68'(v2y[32:0]);
      h3r <= 68'(t2[32:0]) * 68'(t2[32:0]);
      c3 <= c2;
      c3_cc <= c2_cc;
      c3_bb <= c2_bb;
    end
  end

  ctl_t c4;
  logic [67:0] s4, r4;
  logic        c4_cc, c4_bb;
  always_ff @(posedge clk) begin
    if (en) begin
      s4 <= h3x + h3y;
      r4 <= h3r;
      c4 <= c3;
      c4_cc <= c3_cc;
      c4_bb <= c3_bb;
    end
  end

  // Circle pairs need strict overlap, box-circle counts touching as a hit
  ctl_t c5, c5_next;
  always_comb begin
    c5_next = c4;
    if (c4_cc)      c5_next.hit = (s4[67:64] == 0) && (r4 > s4);
    else if (c4_bb) c5_next.hit = c4.hit;
    else            c5_next.hit = (s4 <= r4);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c5 <= c5_next;
    end
  end

  // Normalizer runs in parallel from stage 2 onward
  logic [NFB:0] qx, qy;
  cbct_norm #(.NFB(NFB)) u_norm (
    .clk(clk), .rst(rst), .en(en),
    .ax_in(v2x), .ay_in(v2y), .qx(qx), .qy(qy)
  );

  // Control delay to align with the normalizer output
  localparam int CD = LAT - 5 - 1;
  ctl_t cd [CD+1];
  assign cd[0] = c5;
  for (genvar i = 0; i < CD; i++) begin : g_cd
    always_ff @(posedge clk) begin
      if (en) cd[i+1] <= cd[i];
    end
  end

  // Output stage: pick normal, sign, negate, zero on a miss
  ctl_t c_o;
  logic signed [15:0] nx, ny, one16, fx, fy;
  always_comb begin
    c_o = cd[CD];
    one16 = 16'(1 << NFB);
    if (c_o.use_norm) begin
      nx = c_o.sx ? -16'(qx) : 16'(qx);
      ny = c_o.sy ? -16'(qy) : 16'(qy);
    end else begin
      nx = (c_o.axis_x == 2'd1) ? one16 : ((c_o.axis_x == 2'd2) ? -one16 : 16'sd0);
      ny = (c_o.axis_y == 2'd1) ? one16 : ((c_o.axis_y == 2'd2) ? -one16 : 16'sd0);
    end
    fx = c_o.neg ? -nx : nx;
    fy = c_o.neg ? -ny : ny;
    if (!c_o.hit) begin
      fx = '0;
      fy = '0;
    end
  end

  logic [31:0] od;
  logic        ou;
  always_ff @(posedge clk) begin
    if (en) begin
      od <= {fy, fx};
      ou <= c_o.hit;
    end
  end

  assign m_axis_tdata = od;
  assign m_axis_tuser = ou;

endmodule

// File: tb/tb.sv
// Self-checking testbench for the circle/box collision test pipeline.
module tb import cbct_pkg::*; ();

  localparam int NFB = 14;
  localparam int LATENCY = 56;
  localparam int WDOG_LIMIT = 20000;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] sx, sy;
    logic [30:0] sa, sb;
    logic [31:0] ox, oy;
    logic [30:0] oa, ob;
  } pair_t;

  typedef struct packed {
    logic        hit;
    logic [15:0] nx, ny;
  } hit_t;

  logic clk = 0, rst = 1;
  logic s_axis_tvalid = 0, s_axis_tready;
  logic [255:0] s_axis_tdata = '0;
  logic [1:0] s_axis_tuser = '0;
  logic m_axis_tvalid, m_axis_tready = 0;
  logic [31:0] m_axis_tdata;
  logic m_axis_tuser;

  circle_box_collision_test DUT (.*);

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  pair_t pending[$];
  hit_t expected_hits[$];
  int errors = 0;
  int send_idle = 0, recv_stall = 0;  // percent
  int hold_off = 0;
  bit stim_done = 0;
  bit taken = 0;  // offered pair went through at the last rising edge

  // Exact integer square root of a 66-bit value
  function automatic logic [65:0] isqrt(logic [65:0] d);
    logic [65:0] res, c;
    res = 0;
    for (int b = 32; b >= 0; b--) begin
      c = res | (66'd1 << b);
      if (c * c <= d) res = c;
    end
    return res;
  endfunction

  // Unit vector in Q2.14, zero vector gives zero
  function automatic void unit_vec(longint vx, longint vy, output longint nx, output longint ny);
    logic [63:0] ax, ay, m, len;
    ax = vx < 0 ? -vx : vx;
    ay = vy < 0 ? -vy : vy;
    if (ax == 0 && ay == 0) begin
      nx = 0; ny = 0;
      return;
    end
    m = ax > ay ? ax : ay;
    while (m < 64'h8000_0000) begin
      m <<= 1; ax <<= 1; ay <<= 1;
    end
    len = 64'(isqrt({2'b0, ax} * {2'b0, ax} + {2'b0, ay} * {2'b0, ay}));
    nx = ((ax << NFB) + len / 2) / len;
    ny = ((ay << NFB) + len / 2) / len;
    if (vx < 0) nx = -nx;
    if (vy < 0) ny = -ny;
  endfunction

  function automatic bit box_vs_circle(longint bx, by, hw, hh, cx, cy, r,
                                       output longint nx, output longint ny);
    longint dx, dy, px, py, gx, gy, xp, yp, adx, ady;
    logic [66:0] dist2, rr;
    dx = cx - bx; dy = cy - by;
    px = dx > hw ? hw : (dx < -hw ? -hw : dx);
    py = dy > hh ? hh : (dy < -hh ? -hh : dy);
    gx = px - dx; gy = py - dy;
    adx = dx < 0 ? -dx : dx;
    ady = dy < 0 ? -dy : dy;
    dist2 = 67'(gx) * 67'(gx) + 67'(gy) * 67'(gy);
    rr = 67'(r) * 67'(r);
    nx = 0; ny = 0;
    if (dist2 > rr) return 0;
    if (gx != 0 || gy != 0) unit_vec(gx, gy, nx, ny);
    else begin
      xp = hw + r - adx;
      yp = hh + r - ady;
      if (xp < yp) nx = dx < 0 ? (1 << NFB) : -(1 << NFB);
      else ny = dy < 0 ? (1 << NFB) : -(1 << NFB);
    end
    return 1;
  endfunction

  function automatic hit_t collide(pair_t p);
    longint sx, sy, ox, oy, sa, sb, oa, ob, dx, dy, nx, ny, xp, yp;
    logic [66:0] rs;
    bit hit;
    hit_t r;
    sx = longint'(signed'(p.sx)); sy = longint'(signed'(p.sy));
    ox = longint'(signed'(p.ox)); oy = longint'(signed'(p.oy));
    sa = p.sa; sb = p.sb; oa = p.oa; ob = p.ob;
    nx = 0; ny = 0; hit = 0;
    case (p.kind)
      KIND_CC: begin
        dx = sx - ox; dy = sy - oy;
        rs = sa + oa;
        if (rs * rs > 67'(dx) * 67'(dx) + 67'(dy) * 67'(dy)) begin
          hit = 1;
          unit_vec(dx, dy, nx, ny);
        end
      end
      KIND_BB: begin
        dx = ox - sx; dy = oy - sy;
        xp = sa + oa - (dx < 0 ? -dx : dx);
        yp = sb + ob - (dy < 0 ? -dy : dy);
        if (xp > 0 && yp > 0) begin
          hit = 1;
          if (xp < yp) nx = dx < 0 ? (1 << NFB) : -(1 << NFB);
          else ny = dy < 0 ? (1 << NFB) : -(1 << NFB);
        end
      end
      KIND_BC: hit = box_vs_circle(sx, sy, sa, sb, ox, oy, oa, nx, ny);
      default: begin
        hit = box_vs_circle(ox, oy, oa, ob, sx, sy, sa, nx, ny);
        nx = -nx; ny = -ny;
      end
    endcase
    if (!hit) begin
      nx = 0; ny = 0;
    end
    r.hit = hit; r.nx = nx[15:0]; r.ny = ny[15:0];
    return r;
  endfunction

  // Driver: present next pair at the falling edge, hold it until it is taken
  always @(negedge clk) begin
    if (!rst) begin
      if (!s_axis_tvalid || taken) begin
        if (pending.size() != 0 && $urandom_range(99) >= send_idle) begin
          s_axis_tvalid <= 1;
          s_axis_tuser <= pending[0].kind;
          s_axis_tdata <= {4'b0, pending[0].ob, pending[0].oa, pending[0].oy,
                           pending[0].ox, pending[0].sb, pending[0].sa,
                           pending[0].sy, pending[0].sx};
        end else begin
          s_axis_tvalid <= 0;
        end
      end
    end
  end

  // Receiver: ready at the falling edge, with an optional long hold-off
  always @(negedge clk) begin
    if (!rst) begin
      if (hold_off > 0) begin
        m_axis_tready <= 0;
        hold_off <= hold_off - 1;
      end else begin
        m_axis_tready <= $urandom_range(99) >= recv_stall;
      end
    end
  end

  // Monitor, input capture and watchdog
  int quiet = 0;
  always @(posedge clk) begin
    hit_t want;
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_hits.size() == 0) begin
          $error("unexpected result");
          errors++;
        end else begin
          want = expected_hits.pop_front();
          if (m_axis_tuser !== want.hit) begin
            $error("collided exp %0d got %0d", want.hit, m_axis_tuser);
            errors++;
          end
          if (m_axis_tdata[15:0] !== want.nx) begin
            $error("normal_x exp %0h got %0h", want.nx, m_axis_tdata[15:0]);
            errors++;
          end
          if (m_axis_tdata[31:16] !== want.ny) begin
            $error("normal_y exp %0h got %0h", want.ny, m_axis_tdata[31:16]);
            errors++;
          end
        end
      end
      taken = s_axis_tvalid && s_axis_tready;
      if (taken) begin
        expected_hits.insert(expected_hits.size(), collide(pending.pop_front()));
      end
      if ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready)) quiet <= 0;
      else quiet <= quiet + 1;
      if (quiet >= WDOG_LIMIT) begin
        $display("tb: errors");
        $finish;
      end
    end
  end

  function automatic logic [31:0] rand_coord(int mode);
    case (mode)
      0: return $urandom;
      1: return 32'(signed'($urandom_range(0, 4000)) - 2000) <<< $urandom_range(0, 20);
      default: return 32'(signed'($urandom_range(0, 200)) - 100) <<< 16;
    endcase
  endfunction

  function automatic logic [30:0] rand_size(int mode);
    case (mode)
      0: return 31'($urandom);
      1: return 31'($urandom_range(0, 4000) << $urandom_range(0, 20));
      default: return 31'($urandom_range(0, 80) << 16);
    endcase
  endfunction

  function automatic pair_t rand_pair();
    pair_t p;
    int mode;
    mode = $urandom_range(0, 9) == 0 ? 0 : $urandom_range(1, 2);
    p.kind = 2'($urandom);
    p.sx = rand_coord(mode); p.sy = rand_coord(mode);
    p.ox = rand_coord(mode); p.oy = rand_coord(mode);
    p.sa = rand_size(mode); p.sb = rand_size(mode);
    p.oa = rand_size(mode); p.ob = rand_size(mode);
    // sometimes put both centres on the same point or one axis
    if ($urandom_range(0, 7) == 0) begin
      p.ox = p.sx; p.oy = p.sy;
    end else if ($urandom_range(0, 7) == 0) begin
      p.oy = p.sy;
    end
    return p;
  endfunction

  function automatic pair_t mk(logic [1:0] k, logic [31:0] sx, sy, logic [30:0] sa, sb,
                               logic [31:0] ox, oy, logic [30:0] oa, ob);
    pair_t p;
    p.kind = k; p.sx = sx; p.sy = sy; p.sa = sa; p.sb = sb;
    p.ox = ox; p.oy = oy; p.oa = oa; p.ob = ob;
    return p;
  endfunction

  task automatic queue_pair(pair_t p);
    pending.insert(pending.size(), p);
  endtask

  task automatic drain();
    while (pending.size() != 0 || expected_hits.size() != 0) @(posedge clk);
  endtask

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk) rst <= 0;
    // Directed: extremes, every kind, touching and inside cases
    queue_pair(mk(KIND_CC, 0, 0, 31'h10000, 0, 32'h10000, 0, 31'h10000, 0));
    queue_pair(mk(KIND_CC, 5, 5, 3, 0, 5, 5, 1, 0));
    queue_pair(mk(KIND_CC, 0, 0, 31'h10000, 0, 32'h20000, 0, 31'h10000, 0));
    queue_pair(mk(KIND_CC, 32'h8000_0000, 32'h8000_0000, '1, '1,
                  32'h7FFF_FFFF, 32'h7FFF_FFFF, '1, '1));
    queue_pair(mk(KIND_CC, 32'h7FFF_FFFF, 32'h8000_0000, '1, 0, 0, 0, 0, 0));
    queue_pair(mk(KIND_BB, 0, 0, 10, 10, 5, 2, 10, 10));
    queue_pair(mk(KIND_BB, 0, 0, 10, 10, 20, 0, 10, 10));
    queue_pair(mk(KIND_BB, 0, 0, 10, 10, 3, 3, 10, 10));
    queue_pair(mk(KIND_BB, 0, 0, 10, 10, -3, -9, 10, 10));
    queue_pair(mk(KIND_BB, 32'h8000_0000, 32'h7FFF_FFFF, '1, '1,
                  32'h7FFF_FFFF, 32'h8000_0000, '1, '1));
    queue_pair(mk(KIND_BC, 0, 0, 10, 10, 15, 0, 5, 0));
    queue_pair(mk(KIND_BC, 0, 0, 10, 10, 16, 0, 5, 0));
    queue_pair(mk(KIND_BC, 0, 0, 10, 10, 13, 14, 5, 0));
    queue_pair(mk(KIND_BC, 0, 0, 10, 10, 0, 0, 5, 0));
    queue_pair(mk(KIND_BC, 0, 0, 10, 20, 2, -1, 5, 0));
    queue_pair(mk(KIND_BC, 0, 0, 10, 10, -4, 4, 5, 0));
    queue_pair(mk(KIND_CB, 15, 0, 5, '1, 0, 0, 10, 10));
    queue_pair(mk(KIND_CB, -3, 1, 5, 0, 0, 0, 10, 10));
    queue_pair(mk(KIND_CB, 32'h8000_0000, 32'h8000_0000, '1, '1,
                  32'h7FFF_FFFF, 32'h7FFF_FFFF, '1, '1));
    queue_pair(mk(KIND_CB, 0, 0, 0, 0, 0, 0, 0, 0));
    drain();
    // Random phases: none, sender idle, receiver stall, both
    for (int ph = 0; ph < 4; ph++) begin
      send_idle = (ph == 1) ? 78 : (ph == 3 ? 25 : 0);
      recv_stall = (ph == 2) ? 78 : (ph == 3 ? 25 : 0);
      if (ph == 0) hold_off = 300;  // long receiver hold-off fills the pipeline
      for (int i = 0; i < 185; i++) queue_pair(rand_pair());
      drain();
    end
    repeat (LATENCY + 10) @(posedge clk);
    if (errors == 0) $display("tb: clean");
    else $display("tb: errors");
    $finish;
  end
endmodule
